// ===== hw/rtl/intel_hex_image_loader_macros.svh =====
// Assertion macros shared by the loader checker.
// Each macro takes a label, an antecedent and a consequent; clock is clk, reset arst_n.
`ifndef INTEL_HEX_IMAGE_LOADER_MACROS_SVH
`define INTEL_HEX_IMAGE_LOADER_MACROS_SVH

// same-cycle implication
`define IHL_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ihl check failed");

// next-cycle implication
`define IHL_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ihl check failed");

`endif

// ===== hw/rtl/ihl_pkg.sv =====
// Shared types, codes and helpers for the Intel HEX image loader.
// No dependencies.
`timescale 1ns / 1ps
package ihl_pkg;

	// request codes
	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_CHAR  = 2'd1;
	localparam logic [1:0] REQ_END   = 2'd2;
	localparam logic [1:0] REQ_READ  = 2'd3;

	// load status codes
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_DONE   = 3'd1;
	localparam logic [2:0] ST_CKSUM  = 3'd2;
	localparam logic [2:0] ST_OVFL   = 3'd3;
	localparam logic [2:0] ST_NORST  = 3'd4;

	// line parser phases
	localparam logic [2:0] PH_LINE = 3'd0;
	localparam logic [2:0] PH_SKIP = 3'd1;
	localparam logic [2:0] PH_REC  = 3'd2;
	localparam logic [2:0] PH_TAIL = 3'd3;
	localparam logic [2:0] PH_STOP = 3'd4;

	// record kinds
	localparam logic [7:0] KIND_DATA  = 8'd0;
	localparam logic [7:0] KIND_EOF   = 8'd1;
	localparam logic [7:0] KIND_UPPER = 8'd4;

	// configuration register indexes
	localparam logic CFG_FLASH_LIMIT  = 1'b0;
	localparam logic CFG_SPARE_OFFSET = 1'b1;

	localparam logic [7:0]  CHAR_COLON  = 8'h3A;
	localparam logic [7:0]  CHAR_LF     = 8'h0A;
	localparam logic [7:0]  FILL_BYTE   = 8'hFF;
	localparam logic [16:0] FLASH_RESET = 17'd65536;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  char_code;
		logic [15:0] read_addr;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        format_error;
		logic        eof_missing;
		logic        reset_found;
		logic [23:0] reset_vector;
		logic [31:0] image_start;
		logic [32:0] image_end;
		logic [7:0]  read_data;
	} out_item_t;

	// decode one hex character: bit 4 flags a valid digit
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/ihl_ram.sv =====
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module ihl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write, or read into the output register
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== hw/rtl/ihl_ctrl.sv =====
// Request sequencer: record parser, record commit walk and image clear sweep.
// Depends on ihl_pkg; drives the image and record buffer RAM ports.
`timescale 1ns / 1ps
module ihl_ctrl import ihl_pkg::*; #(
	parameter int IMAGE_BYTES = 65536,
	parameter int RECORD_MAX  = 256,
	parameter int RESET_BYTES = 3
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  in_item_t                       in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output out_item_t                      out_data,
	input  logic                           cfg_we,
	input  logic                           cfg_idx,
	input  logic [16:0]                    cfg_wdata,
	output logic                           img_we,
	output logic [$clog2(IMAGE_BYTES)-1:0] img_addr,
	output logic [7:0]                     img_wdata,
	input  logic [7:0]                     img_rdata,
	output logic                           buf_we,
	output logic [$clog2(RECORD_MAX)-1:0]  buf_addr,
	output logic [7:0]                     buf_wdata,
	input  logic [7:0]                     buf_rdata
);

	localparam int AW   = $clog2(IMAGE_BYTES);
	localparam int RIW  = $clog2(RECORD_MAX);
	localparam int CW   = $clog2(RECORD_MAX + 1);
	localparam int HEAD = (RESET_BYTES > 2) ? RESET_BYTES : 2;

	localparam logic [2:0] SQ_IDLE = 3'd0;
	localparam logic [2:0] SQ_EXEC = 3'd1;
	localparam logic [2:0] SQ_FIN  = 3'd2;
	localparam logic [2:0] SQ_CMT  = 3'd3;
	localparam logic [2:0] SQ_RDW  = 3'd4;
	localparam logic [2:0] SQ_CLR  = 3'd5;

	logic [2:0]  seq_q, seq_d;
	in_item_t    req_s1;
	logic [2:0]  phase_q, phase_d;
	logic [3:0]  nib_q, nib_d;
	logic [9:0]  dc_q, dc_d;
	logic [7:0]  len_q, len_d;
	logic [15:0] ofs_q, ofs_d;
	logic [7:0]  kind_q, kind_d;
	logic [7:0]  sum_q, sum_d;
	logic [15:0] upper_q, upper_d;
	logic [31:0] start_q, start_d;
	logic [32:0] end_q, end_d;
	logic [23:0] rvec_q, rvec_d;
	logic        done_q, done_d;
	logic        fmt_q, fmt_d;
	logic        eofm_q, eofm_d;
	logic        rst_q, rst_d;
	logic [2:0]  status_q, status_d;
	logic [7:0]  head_q [HEAD];
	logic [7:0]  head_d [HEAD];
	logic [16:0] flash_q;
	logic [15:0] spare_q;
	logic [AW-1:0] clr_cnt_q, clr_cnt_d;
	logic [CW-1:0] cmt_cnt_q, cmt_cnt_d;
	logic [CW-1:0] cmt_n_q, cmt_n_d;
	logic          cmt_wr_s1, cmt_wr_d;
	logic [CW-1:0] cmt_idx_s1, cmt_idx_d;
	logic [AW-1:0] base_q, base_d;
	out_item_t     out_q;
	logic          out_valid_q;

	logic          accept, out_free, emit;
	logic [7:0]    rdata_sel;
	logic [4:0]    hx;
	logic [9:0]    dc_inc;
	logic [8:0]    byte_idx, data_idx;
	logic [7:0]    byte_val;
	logic [31:0]   rec_addr;
	logic [32:0]   rec_top, end_max;
	logic [32:0]   base_sum;
	logic [8:0]    n_clip;
	logic [63:0]   rv_acc;
	logic [31:0]   ra_ext;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (seq_q != SQ_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// next-state logic for every request kind
	always_comb begin
		seq_d = seq_q;  phase_d = phase_q;  nib_d = nib_q;  dc_d = dc_q;
		len_d = len_q;  ofs_d = ofs_q;  kind_d = kind_q;  sum_d = sum_q;
		upper_d = upper_q;  start_d = start_q;  end_d = end_q;  rvec_d = rvec_q;
		done_d = done_q;  fmt_d = fmt_q;  eofm_d = eofm_q;  rst_d = rst_q;
		status_d = status_q;  head_d = head_q;
		clr_cnt_d = clr_cnt_q;  cmt_cnt_d = cmt_cnt_q;  cmt_n_d = cmt_n_q;
		cmt_wr_d = 1'b0;  cmt_idx_d = cmt_idx_s1;  base_d = base_q;
		emit = 1'b0;  rdata_sel = 8'd0;
		img_we = 1'b0;  img_addr = '0;  img_wdata = FILL_BYTE;
		buf_we = 1'b0;  buf_addr = '0;  buf_wdata = 8'd0;

		hx       = hex_digit(req_s1.char_code);
		dc_inc   = dc_q + 10'd1;
		byte_idx = dc_inc[9:1] - 9'd1;
		data_idx = byte_idx - 9'd4;
		byte_val = {nib_q, hx[3:0]};
		rec_addr = {upper_q, ofs_q};
		rec_top  = {1'b0, rec_addr} + {25'd0, len_q};
		end_max  = (rec_top > end_q) ? rec_top : end_q;
		base_sum = {17'd0, spare_q} + {1'b0, rec_addr};
		n_clip   = ({1'b0, len_q} < 9'(RECORD_MAX)) ? {1'b0, len_q} : 9'(RECORD_MAX);
		ra_ext   = {16'd0, req_s1.read_addr};
		rv_acc   = 64'd0;
		for (int i = 0; i < RESET_BYTES; i++) begin
			rv_acc = {rv_acc[55:0], head_q[i]};
		end

		unique case (seq_q)
			SQ_IDLE: begin
				if (accept) begin
					seq_d = SQ_EXEC;
				end
			end
			SQ_EXEC: begin
				if (out_free) begin
					seq_d = SQ_IDLE;
					emit  = 1'b1;
					unique case (req_s1.req_type)
						REQ_START: begin
							phase_d = PH_LINE;  nib_d = 4'd0;  dc_d = 10'd0;
							len_d = 8'd0;  ofs_d = 16'd0;  kind_d = 8'd0;  sum_d = 8'd0;
							upper_d = 16'd0;  start_d = '1;  end_d = 33'd0;
							rvec_d = 24'd0;  done_d = 1'b0;  fmt_d = 1'b0;
							eofm_d = 1'b0;  rst_d = 1'b0;  status_d = ST_OK;
							clr_cnt_d = '0;
							seq_d = SQ_CLR;
						end
						REQ_CHAR: begin
							unique case (phase_q)
								PH_LINE: begin
									if (req_s1.char_code == CHAR_COLON) begin
										phase_d = PH_REC;  dc_d = 10'd0;
										sum_d = 8'd0;  len_d = 8'd0;
										for (int i = 0; i < HEAD; i++) begin
											head_d[i] = 8'd0;
										end
									end else if (req_s1.char_code != CHAR_LF) begin
										phase_d = PH_SKIP;
									end
								end
								PH_SKIP, PH_TAIL: begin
									if (req_s1.char_code == CHAR_LF) begin
										phase_d = PH_LINE;
									end
								end
								PH_REC: begin
									if (!hx[4]) begin
										fmt_d = 1'b1;  status_d = ST_CKSUM;
										phase_d = PH_STOP;
									end else begin
										dc_d = dc_inc;
										if (dc_inc[0]) begin
											nib_d = hx[3:0];
										end else begin
											sum_d = sum_q + byte_val;
											if (byte_idx == 9'd0) begin
												len_d = byte_val;
											end else if (byte_idx == 9'd1) begin
												ofs_d = {byte_val, 8'd0};
											end else if (byte_idx == 9'd2) begin
												ofs_d = {ofs_q[15:8], byte_val};
											end else if (byte_idx == 9'd3) begin
												kind_d = byte_val;
											end else if (byte_idx < 9'd4 + {1'b0, len_q}) begin
												if (data_idx < 9'(RECORD_MAX)) begin
													buf_we    = 1'b1;
													buf_addr  = data_idx[RIW-1:0];
													buf_wdata = byte_val;
												end
												for (int i = 0; i < HEAD; i++) begin
													if (data_idx == 9'(i)) begin
														head_d[i] = byte_val;
													end
												end
											end else begin
												phase_d = PH_TAIL;
												emit    = 1'b0;
												seq_d   = SQ_FIN;
											end
										end
									end
								end
								default: begin
								end
							endcase
						end
						REQ_END: begin
							if (status_q <= ST_DONE) begin
								if (!done_q) begin
									eofm_d = 1'b1;
								end
								if (!rst_q) begin
									status_d = ST_NORST;
								end
								phase_d = PH_STOP;
							end
						end
						REQ_READ: begin
							img_addr = ra_ext[AW-1:0];
							emit     = 1'b0;
							seq_d    = SQ_RDW;
						end
						default: begin
						end
					endcase
				end
			end
			SQ_FIN: begin
				emit  = 1'b1;
				seq_d = SQ_IDLE;
				if (sum_q != 8'd0) begin
					status_d = ST_CKSUM;
					phase_d  = PH_STOP;
				end else if (kind_q == KIND_DATA) begin
					if (ofs_q == 16'd0 && {1'b0, len_q} >= 9'(RESET_BYTES)) begin
						rvec_d = rv_acc[23:0];
						rst_d  = 1'b1;
					end
					if (rec_addr < start_q) begin
						start_d = rec_addr;
					end
					end_d = end_max;
					if (end_max > {16'd0, flash_q}) begin
						status_d = ST_OVFL;
						phase_d  = PH_STOP;
					end else if (n_clip != 9'd0) begin
						base_d    = base_sum[AW-1:0];
						cmt_cnt_d = '0;
						cmt_n_d   = n_clip[CW-1:0];
						seq_d     = SQ_CMT;
					end
				end else if (kind_q == KIND_EOF) begin
					if (len_q == 8'd0) begin
						done_d   = 1'b1;
						status_d = ST_DONE;
						phase_d  = PH_STOP;
					end
				end else if (kind_q == KIND_UPPER) begin
					upper_d = {head_q[0], head_q[1]};
				end
			end
			SQ_CMT: begin
				// read buffer entry, write it to the image in the next cycle
				if (cmt_cnt_q != cmt_n_q) begin
					buf_addr  = cmt_cnt_q[RIW-1:0];
					cmt_wr_d  = 1'b1;
					cmt_idx_d = cmt_cnt_q;
					cmt_cnt_d = cmt_cnt_q + CW'(1);
				end else if (!cmt_wr_s1) begin
					seq_d = SQ_IDLE;
				end
				if (cmt_wr_s1) begin
					img_we    = 1'b1;
					img_addr  = base_q + AW'(cmt_idx_s1);
					img_wdata = buf_rdata;
				end
			end
			SQ_RDW: begin
				emit      = 1'b1;
				rdata_sel = img_rdata;
				seq_d     = SQ_IDLE;
			end
			SQ_CLR: begin
				img_we    = 1'b1;
				img_addr  = clr_cnt_q;
				img_wdata = FILL_BYTE;
				clr_cnt_d = clr_cnt_q + AW'(1);
				if (clr_cnt_q == AW'(IMAGE_BYTES - 1)) begin
					seq_d = SQ_IDLE;
				end
			end
			default: begin
				seq_d = SQ_IDLE;
			end
		endcase
	end

	// control and load state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SQ_CLR;  phase_q <= PH_LINE;  nib_q <= 4'd0;  dc_q <= 10'd0;
			len_q <= 8'd0;  ofs_q <= 16'd0;  kind_q <= 8'd0;  sum_q <= 8'd0;
			upper_q <= 16'd0;  start_q <= '1;  end_q <= 33'd0;  rvec_q <= 24'd0;
			done_q <= 1'b0;  fmt_q <= 1'b0;  eofm_q <= 1'b0;  rst_q <= 1'b0;
			status_q <= ST_OK;  flash_q <= FLASH_RESET;  spare_q <= 16'd0;
			clr_cnt_q <= '0;  cmt_cnt_q <= '0;  cmt_n_q <= '0;  cmt_wr_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < HEAD; i++) begin
				head_q[i] <= 8'd0;
			end
		end else begin
			seq_q <= seq_d;  phase_q <= phase_d;  nib_q <= nib_d;  dc_q <= dc_d;
			len_q <= len_d;  ofs_q <= ofs_d;  kind_q <= kind_d;  sum_q <= sum_d;
			upper_q <= upper_d;  start_q <= start_d;  end_q <= end_d;  rvec_q <= rvec_d;
			done_q <= done_d;  fmt_q <= fmt_d;  eofm_q <= eofm_d;  rst_q <= rst_d;
			status_q <= status_d;  head_q <= head_d;
			clr_cnt_q <= clr_cnt_d;  cmt_cnt_q <= cmt_cnt_d;  cmt_n_q <= cmt_n_d;
			cmt_wr_s1 <= cmt_wr_d;
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_FLASH_LIMIT:  flash_q <= cfg_wdata;
					CFG_SPARE_OFFSET: spare_q <= cfg_wdata[15:0];
					default: begin
					end
				endcase
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= in_data;
		end
		cmt_idx_s1 <= cmt_idx_d;
		base_q     <= base_d;
		if (emit) begin
			out_q <= '{status: status_d, format_error: fmt_d, eof_missing: eofm_d,
				reset_found: rst_d, reset_vector: rvec_d, image_start: start_d,
				image_end: end_d, read_data: rdata_sel};
		end
	end

endmodule

// ===== hw/rtl/intel_hex_image_loader.sv =====
// Character, start and end requests are registered on accept; the execute step registers
// the result. Reads, and a record's closing checksum character, first pass a read-wait or
// finish step. One item is in work at a time, so input is held while it is in work; a
// stalled result holds input. A data record then holds input while its stored bytes are
// written to the image. A start request, and reset, sweep the image to 0xFF, input held.
// Reset is asynchronous, active low; configuration writes are taken at any time.
`timescale 1ns / 1ps
module intel_hex_image_loader import ihl_pkg::*; #(
	parameter int IMAGE_BYTES = 65536,
	parameter int RECORD_MAX  = 256,
	parameter int RESET_BYTES = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [16:0] cfg_wdata
);

	localparam int AW  = $clog2(IMAGE_BYTES);
	localparam int RIW = $clog2(RECORD_MAX);

	logic          img_we, buf_we;
	logic [AW-1:0] img_addr;
	logic [RIW-1:0] buf_addr;
	logic [7:0]    img_wdata, img_rdata, buf_wdata, buf_rdata;

	// sequencer
	ihl_ctrl #(
		.IMAGE_BYTES(IMAGE_BYTES),
		.RECORD_MAX (RECORD_MAX),
		.RESET_BYTES(RESET_BYTES)
	) u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
		.out_data, .cfg_we, .cfg_idx, .cfg_wdata,
		.img_we, .img_addr, .img_wdata, .img_rdata,
		.buf_we, .buf_addr, .buf_wdata, .buf_rdata
	);

	// image memory
	ihl_ram #(.WIDTH(8), .DEPTH(IMAGE_BYTES)) u_image (
		.clk, .we(img_we), .addr(img_addr), .wdata(img_wdata), .rdata(img_rdata)
	);

	// record data buffer
	ihl_ram #(.WIDTH(8), .DEPTH(RECORD_MAX)) u_recbuf (
		.clk, .we(buf_we), .addr(buf_addr), .wdata(buf_wdata), .rdata(buf_rdata)
	);

endmodule

// ===== hw/rtl/ihl_checker.sv =====
// Port-level checks for the loader, bound to the top level.
// Depends on ihl_pkg and intel_hex_image_loader_macros.svh.
`timescale 1ns / 1ps
`include "intel_hex_image_loader_macros.svh"
module ihl_checker import ihl_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	`IHL_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
	`IHL_ASSERT_IMP(a_fmt_stops, out_valid && out_data.format_error, out_data.status == ST_CKSUM)
	`IHL_ASSERT_IMP(a_done_eof, out_valid && out_data.status == ST_DONE, !out_data.eof_missing)
	`IHL_ASSERT_IMP(a_vec_flag, out_valid && !out_data.reset_found, out_data.reset_vector == 24'd0)

endmodule

bind intel_hex_image_loader ihl_checker u_ihl_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.out_data(out_data)
);
